### src/lsb_pkg.sv
package lsb_pkg;

  localparam int BIN_W      = 5;
  localparam int MAG_W      = 16;
  localparam int HEIGHT_W   = 8;
  localparam int LEVEL_W    = 8;
  localparam int COARSE_W   = 4;
  localparam int FINE_W     = 5;
  localparam int GROUP_SIZE = 16;
  localparam int GROUP_CNT  = 8;
  localparam int EDGE_COUNT = 129;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [HEIGHT_W-1:0] MAX_HEIGHT = 8'd128;
  localparam logic [HEIGHT_W-1:0] DECAY_STEP = 8'd2;
  localparam logic [LEVEL_W-1:0]  LAST_EDGE  = 8'(EDGE_COUNT - 1);

  // Input kind codes.
  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  typedef enum logic [0:0] {
    OP_UPDATE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [BIN_W-1:0]   bin;
    logic [LEVEL_W-1:0] level;
  } queue_item_t;

  // Threshold k is ceil(32*10^((k+1)/64)); the level is how many of them are reached.
  localparam logic [MAG_W-1:0] LEVEL_EDGES [0:EDGE_COUNT-1] = '{
    16'd34, 16'd35, 16'd36, 16'd37, 16'd39, 16'd40, 16'd42, 16'd43, 16'd45, 16'd46,
    16'd48, 16'd50, 16'd52, 16'd53, 16'd55, 16'd57, 16'd59, 16'd62, 16'd64, 16'd66,
    16'd69, 16'd71, 16'd74, 16'd76, 16'd79, 16'd82, 16'd85, 16'd88, 16'd91, 16'd95,
    16'd98, 16'd102, 16'd105, 16'd109, 16'd113, 16'd117, 16'd122, 16'd126, 16'd131,
    16'd135, 16'd140, 16'd146, 16'd151, 16'd156, 16'd162, 16'd168, 16'd174, 16'd180,
    16'd187, 16'd194, 16'd201, 16'd208, 16'd216, 16'd224, 16'd232, 16'd240, 16'd249,
    16'd258, 16'd268, 16'd278, 16'd288, 16'd298, 16'd309, 16'd320, 16'd332, 16'd344,
    16'd357, 16'd370, 16'd384, 16'd398, 16'd412, 16'd427, 16'd443, 16'd459, 16'd476,
    16'd493, 16'd511, 16'd530, 16'd549, 16'd570, 16'd590, 16'd612, 16'd634, 16'd658,
    16'd682, 16'd707, 16'd733, 16'd759, 16'd787, 16'd816, 16'd846, 16'd877, 16'd909,
    16'd942, 16'd977, 16'd1012, 16'd1049, 16'd1088, 16'd1128, 16'd1169, 16'd1212,
    16'd1256, 16'd1302, 16'd1350, 16'd1399, 16'd1451, 16'd1504, 16'd1559, 16'd1616,
    16'd1675, 16'd1736, 16'd1800, 16'd1866, 16'd1934, 16'd2005, 16'd2079, 16'd2155,
    16'd2234, 16'd2315, 16'd2400, 16'd2488, 16'd2579, 16'd2674, 16'd2772, 16'd2873,
    16'd2978, 16'd3087, 16'd3200, 16'd3318
  };

endpackage

### src/log_spectrum_bar_peak_decay.sv
// Channel | Handshake            | Fields                              | Direction
// input   | in_valid, in_ready   | in_kind, in_bin_index, in_magnitude | in
// result  | out_valid, out_ready | out_bin, out_bar_height             | out
//
// One beat is accepted per cycle and one result leaves per cycle, sustained,
// while out_ready is high. An update passes from input beat to result through
// the front stage, the queue, the read-modify-write stage on the height memory,
// and the output register. Reset empties the pipeline and marks every bar as
// zero. A stalled result port backs up through the queue to in_ready; clear beats
// still drain, since they give no result.
module log_spectrum_bar_peak_decay #(
  parameter int NUM_BINS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_kind,
  input  logic [lsb_pkg::BIN_W-1:0]    in_bin_index,
  input  logic [lsb_pkg::MAG_W-1:0]    in_magnitude,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lsb_pkg::BIN_W-1:0]    out_bin,
  output logic [lsb_pkg::HEIGHT_W-1:0] out_bar_height
);

  // The front stage finds the level from the threshold table in two halves:
  // a coarse count over every sixteenth threshold before the register, and a
  // fine count inside the chosen group after it. Updates to bins outside the bar
  // range are dropped there. Clear and update beats then wait in a two-entry queue.
  logic                 push_valid;
  logic                 push_ready;
  lsb_pkg::queue_item_t push_item;
  logic                 pop_valid;
  logic                 pop_ready;
  lsb_pkg::queue_item_t pop_item;

  lsb_front #(
    .NUM_BINS (NUM_BINS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_bin_index (in_bin_index),
    .in_magnitude (in_magnitude),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_item    (push_item)
  );

  lsb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // The back stage reads the stored height when an item leaves the queue and
  // writes the new one when that item moves on. Back-to-back beats to the same
  // bin take the freshly computed height instead of the memory data.
  lsb_back #(
    .NUM_BINS (NUM_BINS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_item       (pop_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_bin        (out_bin),
    .out_bar_height (out_bar_height)
  );

endmodule

### src/lsb_ram.sv
module lsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/lsb_front.sv
module lsb_front #(
  parameter int NUM_BINS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_kind,
  input  logic [lsb_pkg::BIN_W-1:0] in_bin_index,
  input  logic [lsb_pkg::MAG_W-1:0] in_magnitude,
  output logic                      push_valid,
  input  logic                      push_ready,
  output lsb_pkg::queue_item_t      push_item
);

  logic                         f1_valid_r;
  lsb_pkg::op_t                 f1_op_r;
  logic [lsb_pkg::BIN_W-1:0]    f1_bin_r;
  logic [lsb_pkg::MAG_W-1:0]    f1_mag_r;
  logic [lsb_pkg::COARSE_W-1:0] f1_coarse_r;

  logic [lsb_pkg::COARSE_W-1:0] coarse_nxt;
  logic                         in_range;
  logic                         keep;
  logic [lsb_pkg::FINE_W-1:0]   fine;
  logic [lsb_pkg::LEVEL_W-1:0]  level;

  // Coarse level: how many complete groups of sixteen thresholds are reached.
  always_comb begin
    coarse_nxt = '0;
    for (int g = 0; g < lsb_pkg::GROUP_CNT; g++) begin
      if (in_magnitude >= lsb_pkg::LEVEL_EDGES[g * lsb_pkg::GROUP_SIZE +
                                               lsb_pkg::GROUP_SIZE - 1]) begin
        coarse_nxt = coarse_nxt + 4'd1;
      end
    end
  end

  assign in_range = (9'(in_bin_index) < 9'(NUM_BINS));
  assign keep     = (in_kind == lsb_pkg::KIND_CLEAR) || in_range;
  assign in_ready = !f1_valid_r || push_ready;

  // Out-of-range updates are taken and dropped here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else if (in_ready) begin
      f1_valid_r <= in_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f1_op_r     <= (in_kind == lsb_pkg::KIND_CLEAR) ? lsb_pkg::OP_CLEAR
                                                      : lsb_pkg::OP_UPDATE;
      f1_bin_r    <= in_bin_index;
      f1_mag_r    <= in_magnitude;
      f1_coarse_r <= coarse_nxt;
    end
  end

  // Fine level: thresholds reached inside the selected group.
  always_comb begin
    logic [lsb_pkg::LEVEL_W-1:0] idx;
    logic [lsb_pkg::LEVEL_W-1:0] idx_c;
    fine = '0;
    for (int j = 0; j < lsb_pkg::GROUP_SIZE; j++) begin
      idx   = {f1_coarse_r, 4'(j)};
      idx_c = (idx > lsb_pkg::LAST_EDGE) ? lsb_pkg::LAST_EDGE : idx;
      if ((idx <= lsb_pkg::LAST_EDGE) && (f1_mag_r >= lsb_pkg::LEVEL_EDGES[idx_c])) begin
        fine = fine + 5'd1;
      end
    end
  end

  assign level = {f1_coarse_r, 4'b0000} + 8'(fine);

  assign push_valid      = f1_valid_r;
  assign push_item.op    = f1_op_r;
  assign push_item.bin   = f1_bin_r;
  assign push_item.level = level;

endmodule

### src/lsb_queue.sv
module lsb_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  lsb_pkg::queue_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output lsb_pkg::queue_item_t pop_item
);

  localparam int PW = (lsb_pkg::QUEUE_DEPTH > 1) ? $clog2(lsb_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(lsb_pkg::QUEUE_DEPTH + 1);

  lsb_pkg::queue_item_t slots_r [0:lsb_pkg::QUEUE_DEPTH-1];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push, pop;

  assign push_ready = (count_r != CW'(lsb_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(lsb_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(lsb_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(lsb_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count missed a push");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> !pop)
    else $error("queue popped while empty");

endmodule

### src/lsb_back.sv
module lsb_back #(
  parameter int NUM_BINS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  lsb_pkg::queue_item_t         pop_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lsb_pkg::BIN_W-1:0]    out_bin,
  output logic [lsb_pkg::HEIGHT_W-1:0] out_bar_height
);

  localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  logic                          b1_valid_r;
  lsb_pkg::queue_item_t          b1_item_r;
  logic                          vb_r;
  logic                          hit_r;
  logic                          kill_r;
  logic [lsb_pkg::HEIGHT_W-1:0]  fwd_r;
  logic [NUM_BINS-1:0]           valid_bits_r;
  logic                          out_valid_r;
  logic [lsb_pkg::BIN_W-1:0]     out_bin_r;
  logic [lsb_pkg::HEIGHT_W-1:0]  out_bar_height_r;

  logic                          b1_fire;
  logic                          b1_clear;
  logic                          pop;
  logic                          we;
  logic [AW-1:0]                 b1_addr;
  logic [AW-1:0]                 pop_addr;
  logic [lsb_pkg::HEIGHT_W-1:0]  rdata;
  logic [lsb_pkg::HEIGHT_W-1:0]  h_old;
  logic [lsb_pkg::HEIGHT_W-1:0]  h_step;
  logic [lsb_pkg::HEIGHT_W-1:0]  h_new;

  assign b1_clear  = (b1_item_r.op == lsb_pkg::OP_CLEAR);
  assign b1_fire   = b1_valid_r && (b1_clear || !out_valid_r || out_ready);
  assign pop_ready = !b1_valid_r || b1_fire;
  assign pop       = pop_valid && pop_ready;
  assign we        = b1_fire && !b1_clear;
  assign b1_addr   = AW'(b1_item_r.bin);
  assign pop_addr  = AW'(pop_item.bin);

  lsb_ram #(
    .WIDTH (lsb_pkg::HEIGHT_W),
    .DEPTH (NUM_BINS)
  ) u_heights (
    .clk   (clk),
    .we    (we),
    .waddr (b1_addr),
    .wdata (h_new),
    .re    (pop),
    .raddr (pop_addr),
    .rdata (rdata)
  );

  // The item ahead may have written this bin or cleared all bars in the cycle the
  // read was issued; those cases override the memory data.
  always_comb begin
    if (kill_r) begin
      h_old = '0;
    end else if (hit_r) begin
      h_old = fwd_r;
    end else if (vb_r) begin
      h_old = rdata;
    end else begin
      h_old = '0;
    end
  end

  always_comb begin
    if (h_old < b1_item_r.level) begin
      h_step = b1_item_r.level;
    end else if (h_old > 8'd1) begin
      h_step = h_old - lsb_pkg::DECAY_STEP;
    end else begin
      h_step = '0;
    end
    h_new = (h_step > lsb_pkg::MAX_HEIGHT) ? lsb_pkg::MAX_HEIGHT : h_step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r   <= 1'b0;
      valid_bits_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (pop_ready) begin
        b1_valid_r <= pop_valid;
      end
      if (b1_fire && b1_clear) begin
        valid_bits_r <= '0;
      end else if (we) begin
        valid_bits_r[b1_addr] <= 1'b1;
      end
      if (we) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_item_r <= pop_item;
      vb_r      <= valid_bits_r[pop_addr];
      hit_r     <= we && (b1_item_r.bin == pop_item.bin);
      kill_r    <= b1_fire && b1_clear;
      fwd_r     <= h_new;
    end
    if (we) begin
      out_bin_r        <= b1_item_r.bin;
      out_bar_height_r <= h_new;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_bin        = out_bin_r;
  assign out_bar_height = out_bar_height_r;

  a_height_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_bar_height_r <= lsb_pkg::MAX_HEIGHT))
    else $error("bar height above limit");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (b1_fire && b1_clear) |=> (valid_bits_r == '0))
    else $error("clear left a bar marked valid");

  a_fwd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    b1_valid_r |-> $onehot0({hit_r, kill_r}))
    else $error("forward hit and clear at once");

  a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> b1_valid_r)
    else $error("popped item lost");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

// Checks the spectrum bar block: each update beat carries a bin and an FFT
// magnitude, the bar of that bin either jumps up to the log level of the
// magnitude, capped at 128, or decays by two but not below zero, and one result
// beat returns the bin and the new height. A clear beat zeroes every bar and
// returns nothing. The bench keeps its own copy of all bar heights and
// predicts every result when the input beat is accepted.
module tb_top;

  localparam int N_BARS      = 32;
  localparam int N_THRESH    = 129;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_BEATS = 1900;
  // Beats counted on each side between these marks see no idling at all.
  localparam int CALM_FROM   = 700;
  localparam int CALM_TO     = 1100;

  typedef struct packed {
    logic                         kind;
    logic [lsb_pkg::BIN_W-1:0]    bin;
    logic [lsb_pkg::MAG_W-1:0]    mag;
  } bar_beat_t;

  typedef struct packed {
    logic [lsb_pkg::BIN_W-1:0]    bin;
    logic [lsb_pkg::HEIGHT_W-1:0] height;
  } bar_result_t;

  // The log level is the number of these thresholds that a magnitude reaches.
  // Entry k is ceil(32 * 10^((k+1)/64)), so magnitude 33 and below give 0.
  localparam logic [15:0] BAR_THRESH [0:N_THRESH-1] = '{
    34, 35, 36, 37, 39, 40, 42, 43, 45, 46,
    48, 50, 52, 53, 55, 57, 59, 62, 64, 66,
    69, 71, 74, 76, 79, 82, 85, 88, 91, 95,
    98, 102, 105, 109, 113, 117, 122, 126, 131, 135,
    140, 146, 151, 156, 162, 168, 174, 180, 187, 194,
    201, 208, 216, 224, 232, 240, 249, 258, 268, 278,
    288, 298, 309, 320, 332, 344, 357, 370, 384, 398,
    412, 427, 443, 459, 476, 493, 511, 530, 549, 570,
    590, 612, 634, 658, 682, 707, 733, 759, 787, 816,
    846, 877, 909, 942, 977, 1012, 1049, 1088, 1128, 1169,
    1212, 1256, 1302, 1350, 1399, 1451, 1504, 1559, 1616, 1675,
    1736, 1800, 1866, 1934, 2005, 2079, 2155, 2234, 2315, 2400,
    2488, 2579, 2674, 2772, 2873, 2978, 3087, 3200, 3318
  };

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic                         in_kind;
  logic [lsb_pkg::BIN_W-1:0]    in_bin_index;
  logic [lsb_pkg::MAG_W-1:0]    in_magnitude;
  logic                         out_valid;
  logic                         out_ready;
  logic [lsb_pkg::BIN_W-1:0]    out_bin;
  logic [lsb_pkg::HEIGHT_W-1:0] out_bar_height;

  log_spectrum_bar_peak_decay #(
    .NUM_BINS(N_BARS)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_bin_index  (in_bin_index),
    .in_magnitude  (in_magnitude),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_bin       (out_bin),
    .out_bar_height(out_bar_height)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Beats waiting to be driven, and the results the bar model predicts.
  bar_beat_t   pending_beats[$];
  bar_result_t expected_bars[$];
  bar_beat_t   drive_beat;

  // The bench's own copy of the bar memory.
  logic [lsb_pkg::HEIGHT_W-1:0] bar_mem [N_BARS];

  int errors       = 0;
  int beats_in     = 0;
  int results_seen = 0;
  int n_updates    = 0;
  int n_clears     = 0;
  int n_clamped    = 0;
  int n_rises      = 0;
  int n_decays     = 0;
  int n_to_zero    = 0;
  int quiet_cycles = 0;

  function automatic int mag_to_level(input logic [lsb_pkg::MAG_W-1:0] mag);
    int lvl;
    lvl = 0;
    for (int k = 0; k < N_THRESH; k++) begin
      if (mag >= BAR_THRESH[k]) lvl++;
    end
    return lvl;
  endfunction

  // Applies one accepted beat to the bar copy and queues the result it causes.
  task automatic apply_bar_update(input bar_beat_t b);
    int          lvl;
    int          h;
    bar_result_t r;
    if (b.kind == lsb_pkg::KIND_CLEAR) begin
      for (int i = 0; i < N_BARS; i++) bar_mem[i] = '0;
      n_clears++;
      return;
    end
    // Every 5-bit bin is below the bin count here, so no update is dropped.
    lvl = mag_to_level(b.mag);
    h   = bar_mem[b.bin];
    if (h < lvl) begin
      h = lvl;
      n_rises++;
    end else if (h > 1) begin
      h = h - lsb_pkg::DECAY_STEP;
      n_decays++;
    end else begin
      h = 0;
      n_to_zero++;
    end
    // The clamp comes after the compare, so a level of 129 holds a bar at 128.
    if (h > lsb_pkg::MAX_HEIGHT) begin
      h = lsb_pkg::MAX_HEIGHT;
      n_clamped++;
    end
    bar_mem[b.bin] = h[lsb_pkg::HEIGHT_W-1:0];
    r.bin    = b.bin;
    r.height = h[lsb_pkg::HEIGHT_W-1:0];
    expected_bars.push_back(r);
    n_updates++;
  endtask

  function automatic bit idle_now(input int count);
    if (count >= CALM_FROM && count < CALM_TO) return 1'b0;
    return $urandom_range(0, 99) < 28;
  endfunction

  function automatic bar_beat_t make_beat(input logic kind, input int bin, input int mag);
    bar_beat_t b;
    b.kind = kind;
    b.bin  = bin[lsb_pkg::BIN_W-1:0];
    b.mag  = mag[lsb_pkg::MAG_W-1:0];
    return b;
  endfunction

  // Magnitudes are spread so that the small case, both sides of many
  // thresholds, the top of the table and the full 16-bit range all occur.
  function automatic int pick_magnitude();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) return $urandom_range(0, 40);
    if (sel < 5) return BAR_THRESH[$urandom_range(0, N_THRESH - 1)] + $urandom_range(0, 2) - 1;
    if (sel < 8) return $urandom_range(32, 3400);
    if (sel == 8) return $urandom_range(3318, 65535);
    return $urandom_range(0, 65535);
  endfunction

  // A quarter of the updates hit four hot bins so that bars see long runs of
  // rises and decays rather than a single touch each.
  function automatic int pick_bin();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 3);
    return $urandom_range(0, N_BARS - 1);
  endfunction

  task automatic fill_directed();
    // Small magnitudes, including zero and the values around 32.
    pending_beats.push_back(make_beat(lsb_pkg::KIND_UPDATE, 0, 0));
    pending_beats.push_back(make_beat(lsb_pkg::KIND_UPDATE, 31, 31));
    pending_beats.push_back(make_beat(lsb_pkg::KIND_UPDATE, 1, 32));
    pending_beats.push_back(make_beat(lsb_pkg::KIND_UPDATE, 1, 33));
    // A bar of height one falls straight to zero.
    pending_beats.push_back(make_beat(lsb_pkg::KIND_UPDATE, 2, 34));
    pending_beats.push_back(make_beat(lsb_pkg::KIND_UPDATE, 2, 0));
    // Climb to the top of the table, clamp at 128, hold, then decay.
    pending_beats.push_back(make_beat(lsb_pkg::KIND_UPDATE, 3, 3317));
    pending_beats.push_back(make_beat(lsb_pkg::KIND_UPDATE, 3, 3318));
    pending_beats.push_back(make_beat(lsb_pkg::KIND_UPDATE, 3, 65535));
    pending_beats.push_back(make_beat(lsb_pkg::KIND_UPDATE, 3, 0));
    pending_beats.push_back(make_beat(lsb_pkg::KIND_UPDATE, 3, 0));
    // A bar of height two decays to zero by the normal step.
    pending_beats.push_back(make_beat(lsb_pkg::KIND_UPDATE, 4, 35));
    pending_beats.push_back(make_beat(lsb_pkg::KIND_UPDATE, 4, 0));
    // Alternating bit patterns on bin and magnitude.
    pending_beats.push_back(make_beat(lsb_pkg::KIND_UPDATE, 5'b01010, 16'h5555));
    pending_beats.push_back(make_beat(lsb_pkg::KIND_UPDATE, 5'b10101, 16'hAAAA));
    pending_beats.push_back(make_beat(lsb_pkg::KIND_UPDATE, 16, 16'h8000));
    // Clear with its other fields set high, then with them low.
    pending_beats.push_back(make_beat(lsb_pkg::KIND_CLEAR, 31, 65535));
    pending_beats.push_back(make_beat(lsb_pkg::KIND_UPDATE, 3, 0));
    pending_beats.push_back(make_beat(lsb_pkg::KIND_UPDATE, 3, 3200));
    pending_beats.push_back(make_beat(lsb_pkg::KIND_CLEAR, 0, 0));
    pending_beats.push_back(make_beat(lsb_pkg::KIND_UPDATE, 31, 65535));
    pending_beats.push_back(make_beat(lsb_pkg::KIND_UPDATE, 31, 3318));
    pending_beats.push_back(make_beat(lsb_pkg::KIND_UPDATE, 31, 3087));
  endtask

  task automatic fill_random();
    int count;
    int bin;
    int run;
    count = 0;
    while (count < RANDOM_BEATS) begin
      if ($urandom_range(0, 99) < 2) begin
        pending_beats.push_back(make_beat(lsb_pkg::KIND_CLEAR, $urandom_range(0, N_BARS - 1),
                                          $urandom_range(0, 65535)));
        count++;
      end else if ($urandom_range(0, 99) < 12) begin
        // A peak followed by weak magnitudes on the same bin: the bar has to
        // hold and then fall two at a time.
        bin = pick_bin();
        run = $urandom_range(2, 8);
        pending_beats.push_back(make_beat(lsb_pkg::KIND_UPDATE, bin,
                                          $urandom_range(400, 65535)));
        for (int i = 0; i < run; i++)
          pending_beats.push_back(make_beat(lsb_pkg::KIND_UPDATE, bin,
                                            $urandom_range(0, 300)));
        count += run + 1;
      end else begin
        pending_beats.push_back(make_beat(lsb_pkg::KIND_UPDATE, pick_bin(),
                                          pick_magnitude()));
        count++;
      end
    end
  endtask

  // Driver: an input beat moves on every edge where valid and ready are both
  // high. A new beat is offered only when the slot is free, and valid stays up
  // with the same payload until the beat is taken.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        apply_bar_update(drive_beat);
        beats_in++;
      end
      if (!in_valid || in_ready) begin
        if (pending_beats.size() > 0 && !idle_now(beats_in)) begin
          drive_beat = pending_beats.pop_front();
          in_valid     <= 1'b1;
          in_kind      <= drive_beat.kind;
          in_bin_index <= drive_beat.bin;
          in_magnitude <= drive_beat.mag;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: each result beat is checked against the oldest prediction, and
  // ready is dropped at random to back the block up.
  always @(posedge clk) begin
    bar_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_bars.size() == 0) begin
          $display("%0t: result with nothing expected: bin %0d height %0d",
                   $time, out_bin, out_bar_height);
          errors++;
        end else begin
          want = expected_bars.pop_front();
          if (out_bin !== want.bin) begin
            $display("%0t: out_bin mismatch: expected %0d, actual %0d",
                     $time, want.bin, out_bin);
            errors++;
          end
          if (out_bar_height !== want.height) begin
            $display("%0t: out_bar_height mismatch on bin %0d: expected %0d, actual %0d",
                     $time, want.bin, want.height, out_bar_height);
            errors++;
          end
        end
      end
      out_ready <= !idle_now(results_seen);
    end
  end

  // Watchdog: too many cycles in a row with no beat moving on either side
  // means the block has hung.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_kind      = 1'b0;
    in_bin_index = '0;
    in_magnitude = '0;
    out_ready    = 1'b0;
    drive_beat   = '0;
    for (int i = 0; i < N_BARS; i++) bar_mem[i] = '0;
    fill_directed();
    fill_random();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every beat has gone in and every predicted result came out.
    do @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_bars.size() != 0);
    // Give the four-stage pipeline time to show any stray result.
    repeat (12) @(negedge clk);
    if (expected_bars.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_bars.size());
      errors++;
    end

    $display("Ran %0d input beats: %0d bar updates and %0d clears, %0d results checked.",
             beats_in, n_updates, n_clears, results_seen);
    $display("Bars rose %0d times, decayed %0d, fell to zero %0d, clamped at top %0d.",
             n_rises, n_decays, n_to_zero, n_clamped);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
